// ===== sv/mtst_pkg.sv =====
// ----------------------------------------------------------------------------
// mtst_pkg: shared types and codes for the multi-turn servo tracker
// Command, status and register index codes, channel payload structs, the
// classified command record that crosses the front/back queue, and the slot
// record held in the slot table.
// ----------------------------------------------------------------------------
package mtst_pkg;

   // command codes
   localparam logic [2:0] CMD_REPORT      = 3'd0;
   localparam logic [2:0] CMD_RESET_SLOT  = 3'd1;
   localparam logic [2:0] CMD_LIMIT_PROBE = 3'd2;
   localparam logic [2:0] CMD_MOVE_CHECK  = 3'd3;
   localparam logic [2:0] CMD_RESUME      = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [1:0] STAT_ESTOP     = 2'd2;
   localparam logic [1:0] STAT_TARGET    = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_EMERG_THR    = 2'd0;
   localparam logic [1:0] CSR_LIMIT_THR    = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_COUNT = 2'd2;

   // register reset values
   localparam logic [14:0] EMERG_THR_RESET    = 15'd1000;
   localparam logic [14:0] LIMIT_THR_RESET    = 15'd150;
   localparam logic [5:0]  ACTIVE_COUNT_RESET = 6'd32;

   // encoder geometry: half a turn, and the slot reset position / limit
   localparam logic signed [16:0] HALF_TURN     = 17'sd2048;
   localparam logic signed [15:0] RAW_RESET     = 16'sd2048;
   localparam logic signed [31:0] LIMIT_RESET   = 32'sd2048;
   localparam logic signed [15:0] TARGET_FLOOR  = 16'sd2048;

   typedef enum logic [0:0] {
      BACK_IDLE,
      BACK_EXEC
   } back_state_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [4:0]         servo_index;
      logic [15:0]        pos_raw_word;
      logic [15:0]        load_raw_word;
      logic signed [15:0] target_position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] absolute_position;
      logic signed [15:0] turn_count;
      logic signed [15:0] load_value;
      logic signed [31:0] limit_position;
      logic               limit_found;
      logic               overload;
      logic               emergency_stopped;
   } rsp_type;

   // command after decode in the front end
   typedef struct packed {
      logic [2:0]         command;
      logic [4:0]         servo_index;
      logic               index_ok;
      logic signed [15:0] raw_pos;
      logic signed [15:0] load;
      logic               over_emerg;
      logic               over_limit;
      logic signed [15:0] target;
   } item_type;

   // one entry of the slot table
   typedef struct packed {
      logic signed [15:0] last_raw;
      logic signed [15:0] turns;
      logic signed [31:0] abs_pos;
      logic signed [31:0] upper;
      logic signed [15:0] load;
   } slot_type;

endpackage

// ===== sv/mtst_fifo.sv =====
// ----------------------------------------------------------------------------
// mtst_fifo: two-entry queue
// Registered storage with read and write pointers; the head entry is shown
// while the queue is not empty.
// ----------------------------------------------------------------------------
module mtst_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== sv/mtst_front.sv =====
// ----------------------------------------------------------------------------
// mtst_front: configuration registers and command classification
// Holds the three control registers and turns an incoming request into a
// classified record: index check, sign-magnitude decode, threshold tests.
// ----------------------------------------------------------------------------
module mtst_front #(
   parameter int SLOT_COUNT = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   input  mtst_pkg::req_type req,
   output mtst_pkg::item_type item
);
   import mtst_pkg::*;

   logic [14:0] emerg_thr_ff;
   logic [14:0] limit_thr_ff;
   logic [5:0]  active_count_ff;
   logic [15:0] pos_mag;
   logic [15:0] load_mag;
   logic        below_active;
   logic        below_slots;

   assign csr_ready = 1'b1;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         emerg_thr_ff    <= EMERG_THR_RESET;
         limit_thr_ff    <= LIMIT_THR_RESET;
         active_count_ff <= ACTIVE_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_EMERG_THR:    emerg_thr_ff    <= csr_wdata[14:0];
            CSR_LIMIT_THR:    limit_thr_ff    <= csr_wdata[14:0];
            CSR_ACTIVE_COUNT: active_count_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // classification
   always_comb begin
      pos_mag      = {1'b0, req.pos_raw_word[14:0]};
      load_mag     = {1'b0, req.load_raw_word[14:0]};
      below_active = {1'b0, req.servo_index} < active_count_ff;
      below_slots  = {4'b0, req.servo_index} < 9'(SLOT_COUNT);

      item.command     = req.command;
      item.servo_index = req.servo_index;
      item.index_ok    = below_active && below_slots;
      // negative zero comes out as zero
      item.raw_pos     = req.pos_raw_word[15] ? $signed(16'd0 - pos_mag) : $signed(pos_mag);
      item.load        = req.load_raw_word[15] ? $signed(16'd0 - load_mag) : $signed(load_mag);
      item.over_emerg  = req.load_raw_word[14:0] > emerg_thr_ff;
      item.over_limit  = req.load_raw_word[14:0] > limit_thr_ff;
      item.target      = req.target_position;
   end

endmodule

// ===== sv/mtst_back.sv =====
// ----------------------------------------------------------------------------
// mtst_back: slot table and command execution
// Takes classified commands from the queue, reads the slot record, applies
// the command in the execute state, writes the record back and hands the
// result to the response queue. Holds the global emergency latch.
// ----------------------------------------------------------------------------
module mtst_back #(
   parameter int SLOT_COUNT = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  mtst_pkg::item_type cmd_head,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output mtst_pkg::rsp_type  rsp
);
   import mtst_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   back_state_type     state_ff, state_in;
   item_type           cur_ff;
   slot_type           slot_mem_ff [SLOT_COUNT];
   slot_type           rdata_ff;
   logic [SLOT_COUNT-1:0] seen_ff;
   logic [SLOT_COUNT-1:0] load_ok_ff;
   logic               latch_ff, latch_in;

   logic [7:0]         head_idx_ext;
   logic [7:0]         cur_idx_ext;
   logic [IDX_W-1:0]   head_addr;
   logic [IDX_W-1:0]   cur_addr;
   logic               start;
   logic               seen;
   slot_type           slot_now;
   slot_type           slot_new;
   logic signed [16:0] diff;
   logic signed [15:0] turns_step;
   logic signed [31:0] abs_calc;
   logic               do_write;
   logic               set_seen;
   logic               clr_seen;

   assign head_idx_ext = {3'b0, cmd_head.servo_index};
   assign cur_idx_ext  = {3'b0, cur_ff.servo_index};
   assign head_addr    = head_idx_ext[IDX_W-1:0];
   assign cur_addr     = cur_idx_ext[IDX_W-1:0];
   assign start        = (state_ff == BACK_IDLE) && !cmd_empty && !rsp_full;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (start) begin
               cmd_pop  = 1'b1;
               state_in = BACK_EXEC;
            end
         end
         BACK_EXEC: begin
            rsp_push = 1'b1;
            state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // current command, captured as it leaves the queue
   always_ff @(posedge clock) begin
      if (start) begin
         cur_ff <= cmd_head;
      end
   end

   // slot table: read on start, write at the end of execute
   always_ff @(posedge clock) begin
      if (start) begin
         rdata_ff <= slot_mem_ff[head_addr];
      end
      if (do_write) begin
         slot_mem_ff[cur_addr] <= slot_new;
      end
   end

   // per-slot valid bits; a slot not yet sampled reads as its reset record
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         load_ok_ff <= '0;
         latch_ff   <= 1'b0;
      end else begin
         latch_ff <= latch_in;
         if (set_seen) begin
            seen_ff[cur_addr]    <= 1'b1;
            load_ok_ff[cur_addr] <= 1'b1;
         end else if (clr_seen) begin
            seen_ff[cur_addr] <= 1'b0;
         end
      end
   end

   // command execution
   always_comb begin
      seen = seen_ff[cur_addr];

      slot_now = rdata_ff;
      if (!seen) begin
         slot_now.last_raw = RAW_RESET;
         slot_now.turns    = '0;
         slot_now.abs_pos  = '0;
         slot_now.upper    = LIMIT_RESET;
      end
      if (!load_ok_ff[cur_addr]) begin
         slot_now.load = '0;
      end

      // turn unwrap
      diff = {cur_ff.raw_pos[15], cur_ff.raw_pos} - {slot_now.last_raw[15], slot_now.last_raw};
      turns_step = slot_now.turns;
      if (diff < -HALF_TURN) begin
         turns_step = slot_now.turns + 16'sd1;
      end else if (diff > HALF_TURN) begin
         turns_step = slot_now.turns - 16'sd1;
      end
      abs_calc = $signed({{4{turns_step[15]}}, turns_step, 12'b0})
               + $signed({{16{cur_ff.raw_pos[15]}}, cur_ff.raw_pos});

      slot_new  = slot_now;
      latch_in  = latch_ff;
      do_write  = 1'b0;
      set_seen  = 1'b0;
      clr_seen  = 1'b0;
      rsp.status      = STAT_OK;
      rsp.limit_found = 1'b0;
      rsp.overload    = 1'b0;

      if (state_ff == BACK_EXEC) begin
         if (cur_ff.command == CMD_RESUME) begin
            latch_in = 1'b0;
         end else if (!cur_ff.index_ok) begin
            rsp.status = STAT_BAD_INDEX;
         end else begin
            case (cur_ff.command)
               CMD_REPORT, CMD_LIMIT_PROBE: begin
                  slot_new.last_raw = cur_ff.raw_pos;
                  slot_new.load     = cur_ff.load;
                  if (seen) begin
                     slot_new.turns   = turns_step;
                     slot_new.abs_pos = abs_calc;
                  end else begin
                     slot_new.abs_pos = 32'(cur_ff.raw_pos);
                  end
                  if (cur_ff.over_emerg) begin
                     rsp.overload = 1'b1;
                     latch_in     = 1'b1;
                  end
                  if (cur_ff.command == CMD_LIMIT_PROBE && cur_ff.over_limit) begin
                     slot_new.upper  = slot_new.abs_pos;
                     rsp.limit_found = 1'b1;
                  end
                  do_write = 1'b1;
                  set_seen = 1'b1;
               end
               CMD_RESET_SLOT: begin
                  slot_new.last_raw = RAW_RESET;
                  slot_new.turns    = '0;
                  slot_new.abs_pos  = '0;
                  slot_new.upper    = LIMIT_RESET;
                  clr_seen          = 1'b1;
               end
               CMD_MOVE_CHECK: begin
                  if (latch_ff) begin
                     rsp.status = STAT_ESTOP;
                  end else if (cur_ff.target < TARGET_FLOOR
                               || 32'(cur_ff.target) > slot_now.upper) begin
                     rsp.status = STAT_TARGET;
                  end
               end
               default: ;
            endcase
         end
      end

      // slot fields after the step, zero for an out-of-range index
      if (cur_ff.index_ok) begin
         rsp.absolute_position = slot_new.abs_pos;
         rsp.turn_count        = slot_new.turns;
         rsp.load_value        = slot_new.load;
         rsp.limit_position    = slot_new.upper;
      end else begin
         rsp.absolute_position = '0;
         rsp.turn_count        = '0;
         rsp.load_value        = '0;
         rsp.limit_position    = '0;
      end
      rsp.emergency_stopped = latch_in;
   end

endmodule

// ===== sv/multi_turn_servo_tracker.sv =====
// ----------------------------------------------------------------------------
// multi_turn_servo_tracker: per-servo multi-turn position tracker
// Unwraps single-turn encoder reports into multi-turn positions, latches an
// emergency stop on overload, captures end-stop limits and checks moves.
//
//   channel  ports                          transfer when
//   request  req_push req_full req_data     req_push && !req_full
//   response rsp_empty rsp_pop rsp_data     rsp_pop && !rsp_empty
//   config   csr_valid csr_ready csr_index  csr_valid && csr_ready
//            csr_wdata
//
// In the back end a command first reads its slot record from the single-port
// slot table (BACK_IDLE), then is applied and written back (BACK_EXEC).
// A two-entry queue sits on each side of the back end, so requests keep
// landing while a response waits; a request goes through the command queue,
// the BACK_IDLE read and the BACK_EXEC step before its response shows.
// Reset is synchronous; the slot table needs no clearing pass, per-slot
// valid bits stand in for its reset contents. Config is always ready.
// ----------------------------------------------------------------------------
module multi_turn_servo_tracker #(
   parameter int SLOT_COUNT = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mtst_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mtst_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import mtst_pkg::*;

   item_type item;
   item_type cmd_head;
   logic     cmd_empty;
   logic     cmd_pop;
   rsp_type  rsp_new;
   logic     rsp_full;
   logic     rsp_push;

   // front end: config and classification
   mtst_front #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_data),
      .item      (item)
   );

   // command queue between front and back
   mtst_fifo #(
      .WIDTH($bits(item_type))
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (item),
      .full  (req_full),
      .pop   (cmd_pop),
      .dout  (cmd_head),
      .empty (cmd_empty)
   );

   // back end: slot table and execution
   mtst_back #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   // response queue
   mtst_fifo #(
      .WIDTH($bits(rsp_type))
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_new),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .dout  (rsp_data),
      .empty (rsp_empty)
   );

endmodule

// ===== sv/mtst_checker.sv =====
// ----------------------------------------------------------------------------
// mtst_props: port-level checks for the servo tracker
// Watches the response channel for results that contradict each other or
// the queue discipline.
// ----------------------------------------------------------------------------
module mtst_props (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input mtst_pkg::rsp_type rsp_data
);
   import mtst_pkg::*;

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting response holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("response changed while waiting");

   // a bad index reports no slot data
   a_bad_index_clean: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status == STAT_BAD_INDEX |->
         rsp_data.absolute_position == 0 && rsp_data.turn_count == 0
         && rsp_data.load_value == 0 && rsp_data.limit_position == 0
         && !rsp_data.limit_found && !rsp_data.overload)
      else $error("bad index response carries slot data");

   // a captured limit is the position just reported
   a_limit_capture: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.limit_found |->
         rsp_data.limit_position == rsp_data.absolute_position
         && rsp_data.status == STAT_OK)
      else $error("limit capture mismatch");

   // an overload always leaves the latch set
   a_overload_latch: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.overload |-> rsp_data.emergency_stopped)
      else $error("overload without emergency stop");

endmodule

bind multi_turn_servo_tracker mtst_props u_checker (.*);
